@@ design/tcrc_pkg.sv @@
// Shared types and constants of the typed client registry cursor unit.
`timescale 1ns / 1ps

package tcrc_pkg;

  localparam int KEY_PORT_W = 64;
  localparam int IDX_OUT_W  = 4;
  localparam int CUR_OUT_W  = 5;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_STEP     = 2'd1,
    CMD_RESET    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_TYPE = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic look;
    logic walk;
    logic append;
    logic take_match;
    logic set_full;
    logic set_no_type;
    logic clear_cursor;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic look_hit;
    logic look_done;
    logic full;
    logic want_present;
    logic walk_match;
  } sts_t;

endpackage

@@ design/tcrc_if.sv @@
// Request and result channel interfaces of the typed client registry cursor unit.
`timescale 1ns / 1ps

interface tcrc_req_if import tcrc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [KEY_PORT_W-1:0] client_key;
  logic                  is_train;
  logic                  step_backward;

  modport source (output valid, command, client_key, is_train, step_backward, input ready);
  modport sink   (input valid, command, client_key, is_train, step_backward, output ready);
endinterface

interface tcrc_rsp_if import tcrc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 added;
  logic [IDX_OUT_W-1:0] current_train_index;
  logic [IDX_OUT_W-1:0] current_switch_index;
  logic [CUR_OUT_W-1:0] cursor_index;
  logic                 has_clients;
  logic                 can_fetch_next;
  logic [1:0]           status;

  modport source (output valid, added, current_train_index, current_switch_index,
                  cursor_index, has_clients, can_fetch_next, status, input ready);
  modport sink   (input valid, added, current_train_index, current_switch_index,
                  cursor_index, has_clients, can_fetch_next, status, output ready);
endinterface

@@ design/typed_client_registry_cursor_unit.sv @@
// Top level of the typed client registry cursor unit.
`timescale 1ns / 1ps

// Keeps a table of client keys, each tagged train or switch, with a browsing cursor.
// Requests are taken one at a time; the table has a single read port, so register and
// step walk the filled entries one per cycle, while reset cursor and the unused code
// scan no entries. A finished result sits in an output register, and the next request
// is taken as soon as the previous one has been handed to that register.
// The table needs no clearing after reset: only filled entries are ever read.
module typed_client_registry_cursor_unit import tcrc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_BITS      = 64
) (
  input logic       clk,
  input logic       rst,
  tcrc_req_if.sink  req,
  tcrc_rsp_if.source rsp
);

  ctl_t ctl;
  sts_t sts;

  tcrc_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_command (req.command),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .ctl        (ctl),
    .sts        (sts)
  );

  tcrc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .ctl                  (ctl),
    .sts                  (sts),
    .in_command           (req.command),
    .in_key               (req.client_key),
    .in_is_train          (req.is_train),
    .in_step_backward     (req.step_backward),
    .added                (rsp.added),
    .current_train_index  (rsp.current_train_index),
    .current_switch_index (rsp.current_switch_index),
    .cursor_index         (rsp.cursor_index),
    .has_clients          (rsp.has_clients),
    .can_fetch_next       (rsp.can_fetch_next),
    .status               (rsp.status)
  );

endmodule

@@ design/tcrc_datapath.sv @@
// Datapath: client table, scan pipeline, cursor and pointer registers, result register.
`timescale 1ns / 1ps

module tcrc_datapath import tcrc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_BITS      = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic [1:0]            in_command,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic                  in_is_train,
  input  logic                  in_step_backward,
  output logic                  added,
  output logic [IDX_OUT_W-1:0]  current_train_index,
  output logic [IDX_OUT_W-1:0]  current_switch_index,
  output logic [CUR_OUT_W-1:0]  cursor_index,
  output logic                  has_clients,
  output logic                  can_fetch_next,
  output logic [1:0]            status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CW    = IDX_W + 1;

  logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
  logic                train_mem [TABLE_ENTRIES];

  logic [KEY_BITS-1:0] req_key;
  logic                req_train;
  logic                req_back;

  logic [CW-1:0]       count;
  logic [CW-1:0]       cursor;      // all ones means none
  logic [IDX_W-1:0]    train_ptr;
  logic [IDX_W-1:0]    switch_ptr;
  logic                has_train;
  logic                has_switch;

  logic [CW-1:0]       pos;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic                rd_train;

  logic                added_r;
  status_t             status_r;

  logic                look_issue;
  logic [CW-1:0]       pos_inc;
  logic [CW-1:0]       walk_next;
  logic [IDX_W-1:0]    rd_addr;
  logic [CW+CUR_OUT_W-1:0] cursor_ext;
  logic [IDX_W+IDX_OUT_W-1:0] train_ext;
  logic [IDX_W+IDX_OUT_W-1:0] switch_ext;

  always_comb begin
    look_issue = pos < count;
    pos_inc    = pos + CW'(1);
    // Wrap over the filled entries; the none position counts as just before entry 0.
    if (!req_back) begin
      walk_next = (pos_inc >= count) ? '0 : pos_inc;
    end else if (pos[CW-1] || pos == '0) begin
      walk_next = count - CW'(1);
    end else begin
      walk_next = pos - CW'(1);
    end
    rd_addr = ctl.walk ? walk_next[IDX_W-1:0] : pos[IDX_W-1:0];
  end

  assign sts.look_hit     = cmp_valid && (rd_key == req_key);
  assign sts.look_done    = !look_issue && !cmp_valid;
  assign sts.full         = count == CW'(TABLE_ENTRIES);
  assign sts.want_present = req_train ? has_train : has_switch;
  assign sts.walk_match   = cmp_valid && (rd_train == req_train);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cursor     <= '1;
      train_ptr  <= '0;
      switch_ptr <= '0;
      has_train  <= 1'b0;
      has_switch <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      if (ctl.load) begin
        cmp_valid <= 1'b0;
      end else if (ctl.look) begin
        cmp_valid <= look_issue;
      end else if (ctl.walk) begin
        cmp_valid <= 1'b1;
      end
      if (ctl.clear_cursor) begin
        cursor <= '1;
      end
      if (ctl.append) begin
        count <= count + CW'(1);
        if (req_train) begin
          has_train <= 1'b1;
        end else begin
          has_switch <= 1'b1;
        end
        // The first client ever added becomes current and takes the cursor.
        if (count == '0) begin
          cursor <= '0;
          if (req_train) begin
            train_ptr <= '0;
          end else begin
            switch_ptr <= '0;
          end
        end
      end
      if (ctl.take_match) begin
        cursor <= {1'b0, cmp_idx};
        if (req_train) begin
          train_ptr <= cmp_idx;
        end else begin
          switch_ptr <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_key   <= in_key[KEY_BITS-1:0];
      req_train <= in_is_train;
      req_back  <= in_step_backward;
      pos       <= (in_command == CMD_STEP) ? cursor : '0;
      added_r   <= 1'b0;
      status_r  <= ST_OK;
    end else begin
      if (ctl.look && look_issue) begin
        pos <= pos_inc;
      end else if (ctl.walk) begin
        pos <= walk_next;
      end
      if (ctl.append) begin
        added_r <= 1'b1;
      end
      if (ctl.set_full) begin
        status_r <= ST_FULL;
      end
      if (ctl.set_no_type) begin
        status_r <= ST_NO_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      key_mem[count[IDX_W-1:0]]   <= req_key;
      train_mem[count[IDX_W-1:0]] <= req_train;
    end
    rd_key   <= key_mem[rd_addr];
    rd_train <= train_mem[rd_addr];
    cmp_idx  <= rd_addr;
  end

  assign cursor_ext = {{CUR_OUT_W{cursor[CW-1]}}, cursor};
  assign train_ext  = {{IDX_OUT_W{1'b0}}, train_ptr};
  assign switch_ext = {{IDX_OUT_W{1'b0}}, switch_ptr};

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      added                <= added_r;
      current_train_index  <= train_ext[IDX_OUT_W-1:0];
      current_switch_index <= switch_ext[IDX_OUT_W-1:0];
      cursor_index         <= cursor_ext[CUR_OUT_W-1:0];
      has_clients          <= !cursor[CW-1];
      can_fetch_next       <= cursor[CW-1] || (cursor < count);
      status               <= status_r;
    end
  end

endmodule

@@ design/tcrc_controller.sv @@
// Controller: sequences lookup, append and walk, and owns the result valid flag.
`timescale 1ns / 1ps

module tcrc_controller import tcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  output logic       out_valid,
  input  logic       out_ready,
  output ctl_t       ctl,
  input  sts_t       sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_APPEND = 5'b00100,
    S_WALK   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Take no request while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.load = 1'b1;
          unique case (in_command)
            CMD_REGISTER: state_next = S_LOOK;
            CMD_STEP:     state_next = S_WALK;
            CMD_RESET: begin
              ctl.clear_cursor = 1'b1;
              state_next       = S_FIN;
            end
            default:      state_next = S_FIN;
          endcase
        end
      end
      S_LOOK: begin
        ctl.look = 1'b1;
        if (sts.look_hit) begin
          state_next = S_FIN;
        end else if (sts.look_done) begin
          if (sts.full) begin
            ctl.set_full = 1'b1;
            state_next   = S_FIN;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        ctl.append = 1'b1;
        state_next = S_FIN;
      end
      S_WALK: begin
        if (!sts.want_present) begin
          ctl.set_no_type = 1'b1;
          state_next      = S_FIN;
        end else begin
          ctl.walk = 1'b1;
          if (sts.walk_match) begin
            ctl.take_match = 1'b1;
            state_next     = S_FIN;
          end
        end
      end
      S_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid || out_ready) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a previous one is in progress");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_append_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.append |-> !sts.full)
    else $error("append into a full table");

  a_match_ends_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.take_match |=> (state == S_FIN))
    else $error("walk did not finish on a matching entry");
`endif

endmodule
